// ===== src/fpd_pkg.sv =====
// Shared types and constants for the fault persistence debouncer.
// No dependencies; imported by every module of the block but fpd_ram.
package fpd_pkg;

	localparam int FPD_CHANNELS = 16;   // default channel count
	localparam int TIME_W       = 32;   // millisecond timestamps and persistence times
	localparam int MASK_W       = 16;   // channels that can be marked critical
	localparam int CHAN_W       = 8;    // channel field on the ports
	localparam int CFG_IDX_W    = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_FAIL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_CLEAR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_MASK = 2'd2;

	typedef enum logic [1:0] {
		OP_REPORT        = 2'd0,
		OP_SET_FAIL      = 2'd1,
		OP_SET_CLEAR     = 2'd2,
		OP_CLEAR_LATCHED = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_UNKNOWN = 2'd0,
		ST_PASS    = 2'd1,
		ST_FAIL    = 2'd2
	} bit_state_t;

	typedef struct packed {
		op_t               operation;
		logic [CHAN_W-1:0] channel;
		logic              passed;
		logic [TIME_W-1:0] now_ms;
		logic [TIME_W-1:0] persist_ms;
	} fpd_in_t;

	typedef struct packed {
		logic              status;
		logic [CHAN_W-1:0] channel_out;
		bit_state_t        debounced_state;
		bit_state_t        latched_state;
		logic              changed;
	} fpd_out_t;

	// one channel as seen by the update logic
	typedef struct packed {
		bit_state_t        debounced;
		bit_state_t        latched;
		bit_state_t        live;
		logic [TIME_W-1:0] edge_time;
		logic [TIME_W-1:0] fail_t;
		logic [TIME_W-1:0] clear_t;
		logic              critical;
		logic              passed;
		logic [TIME_W-1:0] now_ms;
	} chan_view_t;

	typedef struct packed {
		bit_state_t        debounced;
		bit_state_t        latched;
		bit_state_t        live;
		logic [TIME_W-1:0] edge_time;
		logic              changed;
	} chan_next_t;

	// write side of the per-channel time store
	typedef struct packed {
		logic              edge_we;
		logic              fail_we;
		logic              clear_we;
		logic [TIME_W-1:0] edge_time;
		logic [TIME_W-1:0] persist;
	} store_wr_t;

	// read side of the per-channel time store
	typedef struct packed {
		logic [TIME_W-1:0] edge_time;
		logic [TIME_W-1:0] fail_ovr;
		logic [TIME_W-1:0] clear_ovr;
	} store_rd_t;

endpackage

// ===== src/fpd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fpd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/fpd_time_store.sv =====
// Per-channel edge times and persistence overrides, held in three RAMs.
// Depends on fpd_pkg and fpd_ram. Read-old RAMs get a one-entry bypass.
module fpd_time_store import fpd_pkg::*; #(
	parameter int CHANNELS = FPD_CHANNELS
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rd_idx,
	output store_rd_t                                  rd,
	input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] wr_idx,
	input  store_wr_t                                  wr
);

	logic              hit;
	logic              edge_hit_q;
	logic              fail_hit_q;
	logic              clear_hit_q;
	logic [TIME_W-1:0] edge_byp_q;
	logic [TIME_W-1:0] persist_byp_q;
	store_rd_t         ram_rd;

	fpd_ram #(.WIDTH(TIME_W), .DEPTH(CHANNELS)) u_edge_ram (
		.clk   (clk),
		.we    (wr.edge_we),
		.waddr (wr_idx),
		.wdata (wr.edge_time),
		.raddr (rd_idx),
		.rdata (ram_rd.edge_time)
	);

	fpd_ram #(.WIDTH(TIME_W), .DEPTH(CHANNELS)) u_fail_ram (
		.clk   (clk),
		.we    (wr.fail_we),
		.waddr (wr_idx),
		.wdata (wr.persist),
		.raddr (rd_idx),
		.rdata (ram_rd.fail_ovr)
	);

	fpd_ram #(.WIDTH(TIME_W), .DEPTH(CHANNELS)) u_clear_ram (
		.clk   (clk),
		.we    (wr.clear_we),
		.waddr (wr_idx),
		.wdata (wr.persist),
		.raddr (rd_idx),
		.rdata (ram_rd.clear_ovr)
	);

	// a write and a read of the same entry at one edge: pass the new data on
	assign hit = (wr_idx == rd_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_hit_q  <= 1'b0;
			fail_hit_q  <= 1'b0;
			clear_hit_q <= 1'b0;
		end else begin
			edge_hit_q  <= hit & wr.edge_we;
			fail_hit_q  <= hit & wr.fail_we;
			clear_hit_q <= hit & wr.clear_we;
		end
	end

	always_ff @(posedge clk) begin
		edge_byp_q    <= wr.edge_time;
		persist_byp_q <= wr.persist;
	end

	always_comb begin
		rd.edge_time = edge_hit_q  ? edge_byp_q    : ram_rd.edge_time;
		rd.fail_ovr  = fail_hit_q  ? persist_byp_q : ram_rd.fail_ovr;
		rd.clear_ovr = clear_hit_q ? persist_byp_q : ram_rd.clear_ovr;
	end

endmodule

// ===== src/fpd_update.sv =====
// Debounce step for one channel: live edge tracking, persistence compare, latch.
// Depends on fpd_pkg. Purely combinational.
module fpd_update import fpd_pkg::*; (
	input  chan_view_t view,
	output chan_next_t nx
);

	bit_state_t        obs;
	bit_state_t        next_st;
	logic              live_chg;
	logic [TIME_W-1:0] edge_t;
	logic [TIME_W-1:0] elapsed;

	always_comb begin
		obs      = view.passed ? ST_PASS : ST_FAIL;
		live_chg = (view.live != obs);
		edge_t   = live_chg ? view.now_ms : view.edge_time;
		elapsed  = view.now_ms - edge_t;  // wraps mod 2^32

		next_st = view.debounced;
		if (obs == ST_PASS) begin
			if (view.debounced == ST_UNKNOWN || elapsed >= view.clear_t) begin
				next_st = ST_PASS;
			end
		end else if (elapsed >= view.fail_t) begin
			next_st = ST_FAIL;
		end

		nx.debounced = next_st;
		nx.live      = obs;
		nx.edge_time = edge_t;
		nx.changed   = (next_st != view.debounced);
		nx.latched   = (nx.changed && next_st == ST_FAIL && view.critical) ?
			ST_FAIL : view.latched;
	end

endmodule

// ===== src/fault_persistence_debouncer.sv =====
// Top level of the fault persistence debouncer: command port, config, channel state.
// Depends on fpd_pkg, fpd_time_store (with fpd_ram) and fpd_update.
//
// Usage:
//  - Command channel: request is taken at a rising edge with start high and
//    busy low. busy stays low, so a command can be issued every cycle.
//  - Result channel: each command gives one result, shown on result for one
//    cycle with done high. The command transfer loads the input register (and
//    issues the RAM reads), then the result register is loaded. Throughput is
//    one command per cycle; the channel state read-modify-write is done
//    between those two registers.
//  - Results cannot be held off; the receiver takes each one in its done cycle.
//  - Config port: cfg_wr with cfg_idx selects default fail time, default clear
//    time or critical mask; other indexes are ignored. Write only while idle.
//  - Reset (arst_n low): defaults and mask zero, all channels unknown, no
//    overrides, no result pending. Edge times and overrides live in RAM and are
//    not cleared; they are only read once written.
module fault_persistence_debouncer import fpd_pkg::*; #(
	parameter int CHANNELS = FPD_CHANNELS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  fpd_in_t              request,
	output logic                 done,
	output fpd_out_t             result,
	input  logic                 cfg_wr,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [TIME_W-1:0]    cfg_wdata
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic              accept;

	// configuration
	logic [TIME_W-1:0] default_fail_q;
	logic [TIME_W-1:0] default_clear_q;
	logic [MASK_W-1:0] crit_mask_q;
	logic [CHANNELS-1:0] crit;

	// input register
	logic              valid_s1;
	fpd_in_t           item_s1;
	logic              ch_ok_s1;
	logic [CH_W-1:0]   idx_s1;

	// per-channel state held in flops
	bit_state_t        debounced_q [CHANNELS];
	bit_state_t        latched_q   [CHANNELS];
	bit_state_t        live_q      [CHANNELS];
	logic [CHANNELS-1:0] fail_ovr_valid_q;
	logic [CHANNELS-1:0] clear_ovr_valid_q;

	store_rd_t         store_rd;
	store_wr_t         store_wr;
	chan_view_t        view;
	chan_next_t        nx;
	logic              is_report;

	// result register
	logic              done_q;
	fpd_out_t          result_q;
	fpd_out_t          result_d;

	// every cycle can take a command
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// ---- config registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_fail_q  <= '0;
			default_clear_q <= '0;
			crit_mask_q     <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				CFG_DEFAULT_FAIL:  default_fail_q  <= cfg_wdata;
				CFG_DEFAULT_CLEAR: default_clear_q <= cfg_wdata;
				CFG_CRITICAL_MASK: crit_mask_q     <= cfg_wdata[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// only the first MASK_W channels have a critical bit
	for (genvar i = 0; i < CHANNELS; i++) begin : g_crit
		if (i < MASK_W) begin : g_bit
			assign crit[i] = crit_mask_q[i];
		end else begin : g_none
			assign crit[i] = 1'b0;
		end
	end

	// ---- input register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= request;
		end
	end

	assign ch_ok_s1  = ({1'b0, item_s1.channel} < (CHAN_W + 1)'(CHANNELS));
	assign idx_s1    = item_s1.channel[CH_W-1:0];
	assign is_report = (item_s1.operation == OP_REPORT);

	// ---- edge times and overrides; read issued with the transfer ----
	always_comb begin
		store_wr.edge_we   = valid_s1 & ch_ok_s1 & is_report;
		store_wr.fail_we   = valid_s1 & ch_ok_s1 & (item_s1.operation == OP_SET_FAIL);
		store_wr.clear_we  = valid_s1 & ch_ok_s1 & (item_s1.operation == OP_SET_CLEAR);
		store_wr.edge_time = nx.edge_time;
		store_wr.persist   = item_s1.persist_ms;
	end

	fpd_time_store #(.CHANNELS(CHANNELS)) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (request.channel[CH_W-1:0]),
		.rd     (store_rd),
		.wr_idx (idx_s1),
		.wr     (store_wr)
	);

	// ---- channel update ----
	always_comb begin
		view.debounced = debounced_q[idx_s1];
		view.latched   = latched_q[idx_s1];
		view.live      = live_q[idx_s1];
		view.edge_time = store_rd.edge_time;
		view.fail_t    = fail_ovr_valid_q[idx_s1]  ? store_rd.fail_ovr  : default_fail_q;
		view.clear_t   = clear_ovr_valid_q[idx_s1] ? store_rd.clear_ovr : default_clear_q;
		view.critical  = crit[idx_s1];
		view.passed    = item_s1.passed;
		view.now_ms    = item_s1.now_ms;
	end

	fpd_update u_update (
		.view (view),
		.nx   (nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				debounced_q[i] <= ST_UNKNOWN;
				latched_q[i]   <= ST_UNKNOWN;
				live_q[i]      <= ST_UNKNOWN;
			end
			fail_ovr_valid_q  <= '0;
			clear_ovr_valid_q <= '0;
		end else if (valid_s1) begin
			case (item_s1.operation)
				OP_REPORT: begin
					if (ch_ok_s1) begin
						debounced_q[idx_s1] <= nx.debounced;
						latched_q[idx_s1]   <= nx.latched;
						live_q[idx_s1]      <= nx.live;
					end
				end
				OP_SET_FAIL: begin
					if (ch_ok_s1) begin
						fail_ovr_valid_q[idx_s1] <= 1'b1;
					end
				end
				OP_SET_CLEAR: begin
					if (ch_ok_s1) begin
						clear_ovr_valid_q[idx_s1] <= 1'b1;
					end
				end
				OP_CLEAR_LATCHED: begin
					// every channel, whatever the channel field says
					for (int i = 0; i < CHANNELS; i++) begin
						latched_q[i] <= debounced_q[i];
					end
				end
				default: ;
			endcase
		end
	end

	// ---- result ----
	always_comb begin
		result_d.channel_out     = item_s1.channel;
		result_d.status          = ~ch_ok_s1 & (item_s1.operation != OP_CLEAR_LATCHED);
		result_d.debounced_state = ST_UNKNOWN;
		result_d.latched_state   = ST_UNKNOWN;
		result_d.changed         = 1'b0;
		if (ch_ok_s1) begin
			case (item_s1.operation)
				OP_REPORT: begin
					result_d.debounced_state = nx.debounced;
					result_d.latched_state   = nx.latched;
					result_d.changed         = nx.changed;
				end
				OP_CLEAR_LATCHED: begin
					result_d.debounced_state = debounced_q[idx_s1];
					result_d.latched_state   = debounced_q[idx_s1];
				end
				default: begin
					result_d.debounced_state = debounced_q[idx_s1];
					result_d.latched_state   = latched_q[idx_s1];
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q <= result_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// ---- checks ----
	// every command in the input register turns into exactly one result
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("command in input register produced no result");

	a_no_stray_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("result without a command");

	// an error result reports nothing about channel state
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status) |->
		(result.debounced_state == ST_UNKNOWN && result.latched_state == ST_UNKNOWN &&
		 !result.changed))
		else $error("error result carries channel state");

	// a debounced change never returns a channel to unknown
	a_change_known: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.changed) |->
		(result.debounced_state == ST_PASS || result.debounced_state == ST_FAIL))
		else $error("debounced state changed to unknown");

endmodule
